[design/gae_pkg.sv]
// ----------------------------------------------------------------------------
// gae_pkg
// Shared word types, register codes and fixed-point helpers for the
// advantage engine.
// ----------------------------------------------------------------------------
package gae_pkg;

   localparam int ENV_W       = 10;
   localparam int Q_W         = 32;
   localparam int COEF_W      = 17;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 50;
   localparam int TERM_W      = PROD_W - FRAC_W;
   localparam int DIFF_W      = Q_W + 1;
   localparam int SUM_W       = 36;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = COEF_W;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA        = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_LAMBDA = 1'b1;

   localparam logic [COEF_W-1:0] GAMMA_RESET        = 17'd64881;
   localparam logic [COEF_W-1:0] GAMMA_LAMBDA_RESET = 17'd61637;

   localparam logic [PROD_W-1:0] ROUND_HALF = 50'd32768;
   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                    operation;
      logic [ENV_W-1:0]        env_index;
      logic signed [Q_W-1:0]   reward;
      logic signed [Q_W-1:0]   value;
      logic                    episode_start;
      logic signed [Q_W-1:0]   bootstrap_value;
      logic                    bootstrap_done;
   } req_type;

   typedef struct packed {
      logic [ENV_W-1:0]        env_out;
      logic signed [Q_W-1:0]   advantage;
      logic signed [Q_W-1:0]   return_value;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] gamma;
      logic [COEF_W-1:0] gamma_lambda;
   } cfg_type;

   typedef struct packed {
      logic signed [Q_W-1:0] acc;
      logic signed [Q_W-1:0] step_value;
      logic                  next_start;
   } state_word_type;

   // Q1.16 coefficient times Q16.16 value, rounded half up back to Q16.16.
   function automatic logic signed [TERM_W-1:0] mul_round(
      input logic [COEF_W-1:0]    coef,
      input logic signed [Q_W-1:0] x
   );
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] b;
      logic [PROD_W-1:0] q;
      a = {{(PROD_W-COEF_W){1'b0}}, coef};
      b = {{(PROD_W-Q_W){x[Q_W-1]}}, x};
      q = a * b + ROUND_HALF;
      return q[PROD_W-1:FRAC_W];
   endfunction

   // Clamp a wide sum to the signed Q16.16 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1) begin
         return v[Q_W-1:0];
      end
      return v[SUM_W-1] ? Q_MIN : Q_MAX;
   endfunction

endpackage

[design/gae_advantage_engine.sv]
// ----------------------------------------------------------------------------
// gae_advantage_engine
// Generalized advantage estimation over many environments, items streamed
// in reverse time order, per-environment state kept in one memory.
// ----------------------------------------------------------------------------
//
//   port group  dir  handshake            word
//   req_*       in   req_valid/req_stall  gae_pkg::req_type (seed or step)
//   rsp_*       out  rsp_valid/rsp_stall  gae_pkg::rsp_type (one per step)
//   csr_*       in   csr_write            17-bit data, index 0 gamma, 1 g*lambda
//
// One word per cycle, sustained, for any mix of environments, while req_stall
// is low. The rate is set by the accumulator loop: multiply, add and clamp close
// in a single stage, with a same-environment predecessor forwarded from the
// write-back register. Reset is synchronous; it clears pipeline valids and
// loads the reset gamma values. The state memory is not cleared: an environment
// is undefined until seeded. req_stall rises only when the output and skid
// entries are both full, and drops in the cycle after rsp_stall lets a word go.
//
module gae_advantage_engine #(
   parameter int ENVS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gae_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gae_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [gae_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gae_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gae_pkg::*;

   localparam int ADDR_W = (ENVS > 1) ? $clog2(ENVS) : 1;

   cfg_type           cfg_ff;
   logic              advance;
   logic              req_accept;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   state_word_type    rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   state_word_type    wr_data;
   logic              push_valid;
   rsp_type           push_data;

   // Stall is a registered flag from the output side; it never looks at valid.
   assign req_stall  = !advance;
   assign req_accept = req_valid && !req_stall;

   // Hold the coefficients; the user must change them only while the block is idle, as the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gamma        <= GAMMA_RESET;
         cfg_ff.gamma_lambda <= GAMMA_LAMBDA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAMMA:        cfg_ff.gamma        <= csr_data;
            CSR_GAMMA_LAMBDA: cfg_ff.gamma_lambda <= csr_data;
         endcase
      end
   end

   gae_state_mem #(
      .ENVS(ENVS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Read at acceptance, update one stage later, write back, then return.
   gae_update_pipe #(
      .ENVS(ENVS)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_accept  (req_accept),
      .in_data    (req_data),
      .cfg        (cfg_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Part the pipeline from the consumer with an output word plus skid.
   gae_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // The skid fills only behind a held output word.
   a_stall_has_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result word waiting");

   // A full skid stays full only while the consumer keeps stalling.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result word");

   // Draining the skid leaves its word in the output register.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("skid drained but output register is empty");

endmodule

[design/gae_state_mem.sv]
// ----------------------------------------------------------------------------
// gae_state_mem
// Per-environment state store: one registered read port, one write port.
// ----------------------------------------------------------------------------
module gae_state_mem #(
   parameter int ENVS = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [((ENVS > 1) ? $clog2(ENVS) : 1)-1:0] rd_addr,
   output gae_pkg::state_word_type  rd_data,
   input  logic                     wr_en,
   input  logic [((ENVS > 1) ? $clog2(ENVS) : 1)-1:0] wr_addr,
   input  gae_pkg::state_word_type  wr_data
);
   import gae_pkg::*;

   state_word_type state_ff [ENVS];
   state_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_ff[wr_addr] <= wr_data;
      end
   end

   // Read returns the old word when the same entry is written in this cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= state_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gae_update_pipe.sv]
// ----------------------------------------------------------------------------
// gae_update_pipe
// Read-modify-write pipeline: forward pending writes, form the TD error and
// the new accumulator, write back, then form the return.
// ----------------------------------------------------------------------------
module gae_update_pipe #(
   parameter int ENVS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_accept,
   input  gae_pkg::req_type         in_data,
   input  gae_pkg::cfg_type         cfg,
   output logic                     rd_en,
   output logic [((ENVS > 1) ? $clog2(ENVS) : 1)-1:0] rd_addr,
   input  gae_pkg::state_word_type  rd_data,
   output logic                     wr_en,
   output logic [((ENVS > 1) ? $clog2(ENVS) : 1)-1:0] wr_addr,
   output gae_pkg::state_word_type  wr_data,
   output logic                     push_valid,
   output gae_pkg::rsp_type         push_data
);
   import gae_pkg::*;

   localparam int ADDR_W = (ENVS > 1) ? $clog2(ENVS) : 1;
   localparam int EXT_W  = 17;

   logic [EXT_W-1:0] env_ext;
   logic             in_range;

   // stage 1: memory data arrives
   logic                  s1_v_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   req_type               s1_req_ff;

   // stage 2: accumulator update and write-back
   logic                     s2_v_ff;
   logic [ADDR_W-1:0]        s2_addr_ff;
   logic                     s2_op_ff;
   logic [ENV_W-1:0]         s2_env_ff;
   logic signed [Q_W-1:0]    s2_value_ff;
   logic signed [Q_W-1:0]    s2_nv_w_ff;
   logic                     s2_ns_w_ff;
   logic                     s2_ns_ff;
   logic signed [TERM_W-1:0] s2_tv_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff;
   logic signed [Q_W-1:0]    s2_acc_ff;
   logic                     s2_hit_ff;

   // last word written, for reads that raced the write
   logic              wb_v_ff;
   logic [ADDR_W-1:0] wb_addr_ff;
   state_word_type    wb_word_ff;

   // stage 3: return
   logic                  s3_v_ff;
   logic [ENV_W-1:0]      s3_env_ff;
   logic signed [Q_W-1:0] s3_acc_ff;
   logic signed [Q_W-1:0] s3_value_ff;

   logic                     hit_s2;
   logic                     hit_wb;
   logic signed [Q_W-1:0]    s1_nv;
   logic                     s1_ns;
   logic signed [Q_W-1:0]    s1_acc;
   logic signed [TERM_W-1:0] s1_tv;
   logic signed [DIFF_W-1:0] s1_diff;
   logic signed [Q_W-1:0]    s1_nv_w;
   logic                     s1_ns_w;

   logic signed [Q_W-1:0]    acc_use;
   logic signed [TERM_W-1:0] s2_ta;
   logic signed [SUM_W-1:0]  s2_sum;
   logic signed [Q_W-1:0]    s2_acc_sat;
   state_word_type           s2_word;

   logic signed [SUM_W-1:0]  s3_sum;

   assign env_ext  = {{(EXT_W-ENV_W){1'b0}}, in_data.env_index};
   assign in_range = env_ext < EXT_W'(ENVS);
   assign rd_en    = advance && in_accept && in_range;
   assign rd_addr  = env_ext[ADDR_W-1:0];

   // Resolve the stored next value and flag against writes still in flight;
   // the item now in stage 2 is newer than the last write.
   always_comb begin
      hit_s2 = s2_v_ff && (s2_addr_ff == s1_addr_ff);
      hit_wb = wb_v_ff && (wb_addr_ff == s1_addr_ff);
      if (hit_s2) begin
         s1_nv = s2_nv_w_ff;
         s1_ns = s2_ns_w_ff;
      end else if (hit_wb) begin
         s1_nv = wb_word_ff.step_value;
         s1_ns = wb_word_ff.next_start;
      end else begin
         s1_nv = rd_data.step_value;
         s1_ns = rd_data.next_start;
      end
      s1_acc  = hit_wb ? wb_word_ff.acc : rd_data.acc;
      s1_tv   = s1_ns ? '0 : mul_round(cfg.gamma, s1_nv);
      s1_diff = {s1_req_ff.reward[Q_W-1], s1_req_ff.reward}
              - {s1_req_ff.value[Q_W-1], s1_req_ff.value};
      s1_nv_w = (s1_req_ff.operation == OP_STEP) ? s1_req_ff.value
                                                 : s1_req_ff.bootstrap_value;
      s1_ns_w = (s1_req_ff.operation == OP_STEP) ? s1_req_ff.episode_start
                                                 : s1_req_ff.bootstrap_done;
   end

   // Close the accumulator recurrence here; a same-env predecessor has just
   // written and sits in the write-back register.
   always_comb begin
      acc_use    = s2_hit_ff ? wb_word_ff.acc : s2_acc_ff;
      s2_ta      = s2_ns_ff ? '0 : mul_round(cfg.gamma_lambda, acc_use);
      s2_sum     = {{(SUM_W-DIFF_W){s2_diff_ff[DIFF_W-1]}}, s2_diff_ff}
                 + {{(SUM_W-TERM_W){s2_tv_ff[TERM_W-1]}}, s2_tv_ff}
                 + {{(SUM_W-TERM_W){s2_ta[TERM_W-1]}}, s2_ta};
      s2_acc_sat = sat_q(s2_sum);
      s2_word.acc        = (s2_op_ff == OP_STEP) ? s2_acc_sat : '0;
      s2_word.step_value = s2_nv_w_ff;
      s2_word.next_start = s2_ns_w_ff;
   end

   assign wr_en   = advance && s2_v_ff;
   assign wr_addr = s2_addr_ff;
   assign wr_data = s2_word;

   assign s3_sum = {{(SUM_W-Q_W){s3_acc_ff[Q_W-1]}}, s3_acc_ff}
                 + {{(SUM_W-Q_W){s3_value_ff[Q_W-1]}}, s3_value_ff};

   assign push_valid             = s3_v_ff;
   assign push_data.env_out      = s3_env_ff;
   assign push_data.advantage    = s3_acc_ff;
   assign push_data.return_value = sat_q(s3_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         wb_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= in_accept && in_range;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && (s2_op_ff == OP_STEP);
         wb_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff  <= env_ext[ADDR_W-1:0];
         s1_req_ff   <= in_data;

         s2_addr_ff  <= s1_addr_ff;
         s2_op_ff    <= s1_req_ff.operation;
         s2_env_ff   <= s1_req_ff.env_index;
         s2_value_ff <= s1_req_ff.value;
         s2_nv_w_ff  <= s1_nv_w;
         s2_ns_w_ff  <= s1_ns_w;
         s2_ns_ff    <= s1_ns;
         s2_tv_ff    <= s1_tv;
         s2_diff_ff  <= s1_diff;
         s2_acc_ff   <= s1_acc;
         s2_hit_ff   <= hit_s2;

         wb_addr_ff  <= s2_addr_ff;
         wb_word_ff  <= s2_word;

         s3_env_ff   <= s2_env_ff;
         s3_acc_ff   <= s2_acc_sat;
         s3_value_ff <= s2_value_ff;
      end
   end

endmodule

[design/gae_out_buffer.sv]
// ----------------------------------------------------------------------------
// gae_out_buffer
// Output register with one skid entry; stops the pipeline only when full.
// ----------------------------------------------------------------------------
module gae_out_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  gae_pkg::rsp_type  push_data,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gae_pkg::rsp_type  rsp_data
);
   import gae_pkg::*;

   logic    out_v_ff;
   rsp_type out_ff;
   logic    skid_v_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign advance   = !skid_v_ff;
   assign push      = advance && push_valid;
   assign pop       = out_v_ff && !rsp_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

endmodule

[tb/gae_advantage_engine_tb.sv]
// ----------------------------------------------------------------------------
// gae_advantage_engine_tb
// Self-checking bench for the advantage engine. Seeds and steps are sent over
// the request channel, and a per-environment predictor builds the expected
// advantage and return for each accepted step. Results are checked in order
// while both channels idle and stall at random under several coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gae_advantage_engine_tb;
   import gae_pkg::*;

   localparam int     ENV_COUNT     = 1024;
   localparam int     PHASE_WORDS   = 320;
   localparam int     SETTLE_CYCLES = 8;
   localparam longint CYCLE_LIMIT   = 500000;
   localparam longint SAT_HI        = 64'sd2147483647;
   localparam longint SAT_LO        = -64'sd2147483648;

   // -------------------------------------------------------------------------
   // Advantage book: per-environment copy of the accumulator, next value and
   // next start flag, plus the queue of advantage words still owed.
   // -------------------------------------------------------------------------
   class advantage_book;
      logic signed [Q_W-1:0] acc_mem    [ENV_COUNT];
      logic signed [Q_W-1:0] val_mem    [ENV_COUNT];
      logic                  next_start [ENV_COUNT];
      logic [COEF_W-1:0]     gamma_q;
      logic [COEF_W-1:0]     gamma_lambda_q;
      rsp_type               expected_adv [$];
      int                    mismatches;
      int                    results_seen;

      function new();
         gamma_q        = GAMMA_RESET;
         gamma_lambda_q = GAMMA_LAMBDA_RESET;
         mismatches     = 0;
         results_seen   = 0;
      endfunction

      function void set_coef(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] v);
         if (idx == CSR_GAMMA) begin
            gamma_q = v;
         end else begin
            gamma_lambda_q = v;
         end
      endfunction

      // Q1.16 times Q16.16, round half up, floor back to Q16.16.
      function longint discount(logic [COEF_W-1:0] coef, logic signed [Q_W-1:0] x);
         longint p;
         p = longint'(coef) * longint'(x) + 64'sd32768;
         return p >>> 16;
      endfunction

      function logic signed [Q_W-1:0] clamp(longint v);
         if (v > SAT_HI) return Q_MAX;
         if (v < SAT_LO) return Q_MIN;
         return v[Q_W-1:0];
      endfunction

      function void note_request(req_type w);
         int                    e;
         longint                sum;
         logic signed [Q_W-1:0] adv;
         rsp_type               r;
         e = int'(w.env_index);
         if (w.operation == OP_SEED) begin
            acc_mem[e]    = '0;
            val_mem[e]    = w.bootstrap_value;
            next_start[e] = w.bootstrap_done;
            return;
         end
         sum = longint'(w.reward) - longint'(w.value);
         // terminal next step: drop both discounted terms
         if (!next_start[e]) begin
            sum += discount(gamma_q, val_mem[e]) + discount(gamma_lambda_q, acc_mem[e]);
         end
         adv            = clamp(sum);
         r.env_out      = w.env_index;
         r.advantage    = adv;
         r.return_value = clamp(longint'(adv) + longint'(w.value));
         acc_mem[e]     = adv;
         val_mem[e]     = w.value;
         next_start[e]  = w.episode_start;
         expected_adv   = {expected_adv, r};
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_adv.size() == 0) begin
            $error("unexpected result word for env %0d", got.env_out);
            mismatches++;
            return;
         end
         want = expected_adv.pop_front();
         if (got.env_out !== want.env_out) begin
            $error("env_out: expected %0d, got %0d", want.env_out, got.env_out);
            mismatches++;
         end
         if (got.advantage !== want.advantage) begin
            $error("advantage: expected %0d, got %0d", want.advantage, got.advantage);
            mismatches++;
         end
         if (got.return_value !== want.return_value) begin
            $error("return_value: expected %0d, got %0d", want.return_value,
                   got.return_value);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_adv.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_GAMMA;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   gae_advantage_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   advantage_book book = new();

   bit      seeded [ENV_COUNT];    // env has seen a seed; steps only go to these
   req_type directed [$];
   int      last_env      = 0;
   int      words_sent    = 0;
   int      steps_sent    = 0;
   int      settings_done = 0;
   longint  cycle_count   = 0;
   int      stall_mode    = 0;
   int      stall_run     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Observe all three ports at the rising edge, in one process so the order
   // of bookkeeping within a step is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_request(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
         if (csr_write) book.set_coef(csr_index, csr_data);
      end
   end

   // Receiver back-pressure: hold each mode for a random run of cycles. Mode
   // zero never stalls, the others stall lightly, heavily or every other cycle.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(4, 100);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 99) < 80);
         end
         default: begin
            rsp_stall <= stall_run[0];
         end
      endcase
   end

   // Present one word at the falling edge and hold it until accepted. Valid
   // stays high on return so back-to-back words need no gap.
   task automatic send_word(req_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (w.operation == OP_SEED) begin
         seeded[w.env_index] = 1'b1;
      end else begin
         steps_sent++;
      end
   endtask

   task automatic idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Drop valid, wait for every owed result, then let trailing seeds settle
   // so that the block is quiet before a coefficient write.
   task automatic drain_and_settle();
      idle_sender(1);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic req_type make_word(logic op, int env, logic signed [Q_W-1:0] rw,
                                         logic signed [Q_W-1:0] val, logic st,
                                         logic signed [Q_W-1:0] bv, logic bd);
      req_type w;
      w.operation       = op;
      w.env_index       = ENV_W'(env);
      w.reward          = rw;
      w.value           = val;
      w.episode_start   = st;
      w.bootstrap_value = bv;
      w.bootstrap_done  = bd;
      return w;
   endfunction

   // Append one word to the directed list.
   function automatic void add_directed(req_type w);
      directed = {directed, w};
   endfunction

   // Q16.16 operand: extremes, raw bits, a realistic +/-10.0 band, near zero.
   function automatic logic signed [Q_W-1:0] pick_q();
      case ($urandom_range(0, 9))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2, 3:    return $urandom;
         4:       return $urandom_range(0, 64) - 32;
         default: return $urandom_range(0, 1310720) - 655360;
      endcase
   endfunction

   // Favor repeats and a small pool so one environment builds long chains
   // and same-environment words land back to back.
   function automatic int pick_env();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return last_env;
      if (r < 75) return $urandom_range(0, 7);
      if (r < 85) return ENV_COUNT - 1 - $urandom_range(0, 3);
      return $urandom_range(0, ENV_COUNT - 1);
   endfunction

   // Steps only on seeded environments; otherwise seed, and reseed now and
   // then to restart a chain. Ignored fields always carry random content.
   function automatic req_type random_word();
      int      e;
      req_type w;
      e = pick_env();
      w.operation       = (!seeded[e] || $urandom_range(0, 99) < 8) ? OP_SEED : OP_STEP;
      w.env_index       = ENV_W'(e);
      w.reward          = pick_q();
      w.value           = pick_q();
      w.episode_start   = ($urandom_range(0, 9) == 0);
      w.bootstrap_value = pick_q();
      w.bootstrap_done  = ($urandom_range(0, 4) == 0);
      last_env = e;
      return w;
   endfunction

   initial begin
      logic [COEF_W-1:0] gamma_set [6];
      logic [COEF_W-1:0] lambda_set [6];
      int                burst_left;

      // Coefficient settings per phase: a realistic draw, the extremes, then zero gamma with a random gamma*lambda.
      gamma_set[0] = COEF_W'($urandom_range(58982, 65536));
      lambda_set[0] = COEF_W'($urandom_range(52428, 65536));
      gamma_set[1] = 17'd0;      lambda_set[1] = 17'd0;
      gamma_set[2] = 17'd65536;  lambda_set[2] = 17'd65536;
      gamma_set[3] = 17'd131071; lambda_set[3] = 17'd131071;
      gamma_set[4] = 17'd65536;  lambda_set[4] = 17'd0;
      gamma_set[5] = 17'd0;      lambda_set[5] = COEF_W'($urandom_range(0, 131071));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset coefficients.
      // Saturate high, then low; the third step sees a terminal next step.
      add_directed(make_word(OP_SEED, 0, -1, -1, 1'b1, Q_MAX, 1'b0));
      add_directed(make_word(OP_STEP, 0, Q_MAX, Q_MIN, 1'b0, Q_MIN, 1'b1));
      add_directed(make_word(OP_STEP, 0, Q_MIN, Q_MAX, 1'b1, Q_MAX, 1'b1));
      add_directed(make_word(OP_STEP, 0, 32'sh0001_0000, 32'sh0000_8000, 1'b0,
                             0, 1'b0));
      // Episode ended after the last step: first step has no discounted terms.
      add_directed(make_word(OP_SEED, 1023, Q_MAX, Q_MIN, 1'b0, Q_MIN, 1'b1));
      add_directed(make_word(OP_STEP, 1023, Q_MAX, 0, 1'b0, Q_MAX, 1'b0));
      // Most negative bootstrap value through the discount.
      add_directed(make_word(OP_SEED, 1023, 0, 0, 1'b1, Q_MIN, 1'b0));
      add_directed(make_word(OP_STEP, 1023, 0, 0, 1'b0, 0, 1'b1));
      add_directed(make_word(OP_STEP, 1023, Q_MIN, Q_MIN, 1'b0, Q_MAX, 1'b1));
      // Large value against a large bootstrap value; the return stays in range.
      add_directed(make_word(OP_SEED, 512, Q_MIN, Q_MAX, 1'b1, 32'sh7FFF_0000, 1'b0));
      add_directed(make_word(OP_STEP, 512, 32'sh0001_0000, Q_MAX, 1'b0, Q_MIN, 1'b1));
      // Back-to-back chain on one environment, with an episode start inside.
      add_directed(make_word(OP_SEED, 1, 0, 0, 1'b0, 32'sh0002_0000, 1'b0));
      add_directed(make_word(OP_STEP, 1, 32'sh0001_0000, 32'sh0003_0000, 1'b0, 0, 1'b0));
      add_directed(make_word(OP_STEP, 1, 32'sh0000_4000, 32'sh0002_8000, 1'b1, 0, 1'b0));
      add_directed(make_word(OP_STEP, 1, -32'sh0001_0000, 32'sh0001_0000, 1'b0, 0, 1'b0));
      add_directed(make_word(OP_STEP, 1, 32'sh0002_0000, -32'sh0000_8000, 1'b0, 0, 1'b0));
      add_directed(make_word(OP_STEP, 1, 0, 32'sh0000_0001, 1'b0, 0, 1'b0));
      // Alternating index bits, with tiny negative operands for the rounding.
      add_directed(make_word(OP_SEED, 341, 0, 0, 1'b0, -1, 1'b0));
      add_directed(make_word(OP_STEP, 341, -1, 1, 1'b0, 0, 1'b0));
      add_directed(make_word(OP_SEED, 682, 0, 0, 1'b0, 32'sh0000_0001, 1'b0));
      add_directed(make_word(OP_STEP, 682, 1, -1, 1'b1, 0, 1'b0));
      foreach (directed[i]) send_word(directed[i]);
      drain_and_settle();

      // Random phases, one per coefficient setting. The sender runs in bursts
      // with random gaps, sometimes none, between them.
      for (int p = 0; p < 6; p++) begin
         write_coef(CSR_GAMMA, gamma_set[p]);
         write_coef(CSR_GAMMA_LAMBDA, lambda_set[p]);
         settings_done++;
         burst_left = 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
            end
            burst_left--;
            send_word(random_word());
         end
         drain_and_settle();
      end

      $display("summary: %0d words sent, %0d of them steps, %0d results checked",
               words_sent, steps_sent, book.results_seen);
      $display("summary: %0d coefficient settings, %0d field mismatches",
               settings_done, book.mismatches);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
